@@ rtl/core/hsc_pkg.sv @@
// shared constants, types and character class functions for the host name checker
package hsc_pkg;

  localparam int unsigned MaxNameLengthDef  = 253;
  localparam int unsigned MaxLabelLengthDef = 63;

  localparam int unsigned TotalLenW = 9;
  localparam int unsigned LabelLenW = 7;
  localparam int unsigned DotCntW   = 3;

  localparam logic [7:0] CharDot    = 8'h2e;
  localparam logic [7:0] CharHyphen = 8'h2d;

  localparam logic [DotCntW-1:0] IpDotCount = DotCntW'(3);

  localparam logic RejectIpReset = 1'b1;

  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] ch;
  } hsc_step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

@@ rtl/core/hsc_eval.sv @@
// per-name counters and flags, and the verdict for the byte in flight
module hsc_eval #(
  parameter int unsigned MaxNameLength  = hsc_pkg::MaxNameLengthDef,
  parameter int unsigned MaxLabelLength = hsc_pkg::MaxLabelLengthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsc_pkg::hsc_step_t step_i,
  input  logic              reject_ip_i,
  output logic              name_ok_o
);
  import hsc_pkg::*;

  localparam logic [TotalLenW-1:0] NameMax  = TotalLenW'(MaxNameLength);
  localparam logic [LabelLenW-1:0] LabelMax = LabelLenW'(MaxLabelLength);

  logic [TotalLenW-1:0] total_q, total_d;
  logic [LabelLenW-1:0] label_q, label_d;
  logic [DotCntW-1:0]   dots_q, dots_d;
  logic                 hyph_q, hyph_d;
  logic                 err_q, err_d;
  logic                 digits_q, digits_d;
  logic                 is_dot, is_hyph, is_dig, is_let, err_fin;

  always_comb begin
    is_dot  = (step_i.ch == CharDot);
    is_hyph = (step_i.ch == CharHyphen);
    is_dig  = is_digit(step_i.ch);
    is_let  = is_letter(step_i.ch);

    err_d    = err_q;
    total_d  = total_q;
    label_d  = label_q;
    dots_d   = dots_q;
    hyph_d   = hyph_q;
    digits_d = digits_q;

    if (total_q >= NameMax) begin
      err_d = 1'b1;
    end else begin
      total_d = total_q + TotalLenW'(1);
    end

    if (is_dot) begin
      if ((label_q == '0) || hyph_q || step_i.last) begin
        err_d = 1'b1;
      end
      label_d = '0;
      hyph_d  = 1'b0;
      if (dots_q != '1) begin
        dots_d = dots_q + DotCntW'(1);
      end
    end else begin
      if (!is_dig && !is_let && !is_hyph) begin
        err_d = 1'b1;
      end
      if (is_hyph && (label_q == '0)) begin
        err_d = 1'b1;
      end
      if (label_q >= LabelMax) begin
        err_d = 1'b1;
      end else begin
        label_d = label_q + LabelLenW'(1);
      end
      hyph_d = is_hyph;
      if (!is_dig) begin
        digits_d = 1'b0;
      end
    end

    err_fin   = err_d | hyph_d | (reject_ip_i & digits_d & (dots_d == IpDotCount));
    name_ok_o = ~err_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      label_q  <= '0;
      dots_q   <= '0;
      hyph_q   <= 1'b0;
      err_q    <= 1'b0;
      digits_q <= 1'b1;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        total_q  <= '0;
        label_q  <= '0;
        dots_q   <= '0;
        hyph_q   <= 1'b0;
        err_q    <= 1'b0;
        digits_q <= 1'b1;
      end else begin
        total_q  <= total_d;
        label_q  <= label_d;
        dots_q   <= dots_d;
        hyph_q   <= hyph_d;
        err_q    <= err_d;
        digits_q <= digits_d;
      end
    end
  end

endmodule

@@ rtl/core/hostname_syntax_checker.sv @@
// top level of the host name syntax checker
//
// a host name arrives one byte per transfer on the input channel
// (in_valid_i / in_stall_o), with final_byte_i set on its last byte
// one verdict per name leaves on the output channel (out_valid_o /
// out_stall_i); name_ok_o is 1 when the whole name passed
// non-final bytes produce no output transfer
// a byte is taken into an input register, then checked and folded into
// the per-name counters as it leaves; the verdict register is loaded
// then, so a verdict follows its final byte through both registers
// throughput is one byte per cycle, set by the single input register,
// as long as no final byte is held in it behind a stalled verdict
// while a verdict waits under out_stall_i, non-final bytes keep flowing;
// only a following final byte is held in the input register, with
// in_stall_o high for as long as the waiting verdict stays stalled
// reset clears all counters, empties both registers and sets the
// ip literal reject mode; cfg_we_i writes that mode from cfg_data_i
module hostname_syntax_checker #(
  parameter int unsigned MaxNameLength  = hsc_pkg::MaxNameLengthDef,
  parameter int unsigned MaxLabelLength = hsc_pkg::MaxLabelLengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] name_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       name_ok_o
);
  import hsc_pkg::*;

  logic       reject_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_final_q;
  logic       out_valid_q;
  logic       name_ok_q;
  logic       advance;
  logic       in_xfer;
  logic       verdict;
  hsc_step_t  step;

  assign advance    = s1_valid_q && !(s1_final_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign step.fire = advance;
  assign step.last = s1_final_q;
  assign step.ch   = s1_byte_q;

  hsc_eval #(
    .MaxNameLength  (MaxNameLength),
    .MaxLabelLength (MaxLabelLength)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .reject_ip_i (reject_q),
    .name_ok_o   (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q    <= RejectIpReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reject_q <= cfg_data_i;
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance && s1_final_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= name_byte_i;
      s1_final_q <= final_byte_i;
    end
    if (advance && s1_final_q) begin
      name_ok_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign name_ok_o   = name_ok_q;

endmodule

@@ rtl/core/hsc_checker.sv @@
// port level checks for the host name checker and their bind
module hsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       final_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       name_ok_o
);

  // a verdict waiting under stall holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(name_ok_o))
    else $error("verdict changed while stalled");

  // input only backs up behind a stalled verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled verdict");

  // a fresh verdict follows a final byte transfer through the input and verdict registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && final_byte_i, 2))
    else $error("verdict without a final byte transfer");

endmodule

bind hostname_syntax_checker hsc_checker u_hsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .final_byte_i (final_byte_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .name_ok_o    (name_ok_o)
);
